// ===== src/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, widths and the record ordering function for the record sorter.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int SCORE_W = 10;
    localparam int NAME_W  = 32;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name_high;
        logic [NAME_W-1:0]  name_low;
        logic               final_record;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] out_score;
        logic [NAME_W-1:0]  out_name_high;
        logic [NAME_W-1:0]  out_name_low;
        logic               end_of_run;
        logic               records_dropped;
    } t_out_item;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name_high;
        logic [NAME_W-1:0]  name_low;
    } t_record;

    // controller -> datapath
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_dp_cmd;

    // controller -> output flags
    typedef struct packed {
        logic valid;
        logic last;
        logic dropped;
    } t_emit_stat;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // true when record a must come out before record b
    function automatic logic goes_before(input t_record a, input t_record b);
        logic res;
        if (a.score != b.score) begin
            res = a.score > b.score;
        end else if (a.name_high != b.name_high) begin
            res = a.name_high < b.name_high;
        end else begin
            res = a.name_low < b.name_low;
        end
        return res;
    endfunction

endpackage

// ===== src/record_sort_score_desc_name_asc_core.sv =====
`timescale 1ns / 1ps
// Latency: a record is placed in its sorted position in the cycle it is taken;
//   the first result appears the cycle after the final item is taken.
// Throughput: one record per cycle while loading (one compare per chain cell);
//   unloading emits the stored records in sorted order, busy high throughout.
// Results cannot be stalled. Synchronous active-low reset empties the set.
// ----------------------------------------------------------------------------
// record_sort_score_desc_name_asc_core
// Record sorter: score descending, then name ascending, with overflow flag.
// ----------------------------------------------------------------------------
module record_sort_score_desc_name_asc_core
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    t_dp_cmd          w_cmd;
    t_emit_stat       w_stat;
    logic [CNT_W-1:0] w_count;
    t_record          w_rec;
    t_record          w_head;

    assign w_rec.score     = i_item.score;
    assign w_rec.name_high = i_item.name_high;
    assign w_rec.name_low  = i_item.name_low;

    rss_ctrl #(
        .MAX_RECORDS(MAX_RECORDS),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_final(i_item.final_record),
        .o_busy (busy),
        .o_cmd  (w_cmd),
        .o_count(w_count),
        .o_stat (w_stat)
    );

    rss_datapath #(
        .MAX_RECORDS(MAX_RECORDS),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_count(w_count),
        .i_rec  (w_rec),
        .o_head (w_head)
    );

    assign o_valid                  = w_stat.valid;
    assign o_result.out_score       = w_head.score;
    assign o_result.out_name_high   = w_head.name_high;
    assign o_result.out_name_low    = w_head.name_low;
    assign o_result.end_of_run      = w_stat.last;
    assign o_result.records_dropped = w_stat.dropped;

endmodule

// ===== src/rss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_datapath
// Insertion chain of record cells kept in sorted order; shifts toward cell 0
// to unload.
// ----------------------------------------------------------------------------
module rss_datapath
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    input  logic [CNT_W-1:0] i_count,
    input  t_record          i_rec,
    output t_record          o_head
);

    t_record r_cell [MAX_RECORDS];
    logic    w_before [MAX_RECORDS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
            // empty cells sit after every record
            assign w_before[gi] = (CNT_W'(gi) >= i_count) ||
                                  goes_before(i_rec, r_cell[gi]);

            always_ff @(posedge i_clk) begin
                if (i_cmd.shift_out) begin
                    if (gi < MAX_RECORDS - 1) begin
                        r_cell[gi] <= r_cell[(gi < MAX_RECORDS - 1) ? gi + 1 : gi];
                    end
                end else if (i_cmd.insert && w_before[gi]) begin
                    if (gi == 0) begin
                        r_cell[gi] <= i_rec;
                    end else if (w_before[(gi > 0) ? gi - 1 : 0]) begin
                        r_cell[gi] <= r_cell[(gi > 0) ? gi - 1 : 0];
                    end else begin
                        r_cell[gi] <= i_rec;
                    end
                end
            end
        end
    endgenerate

    assign o_head = r_cell[0];

endmodule

// ===== src/rss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_ctrl
// Load/emit sequencer: record count, overflow flag and unload countdown.
// ----------------------------------------------------------------------------
module rss_ctrl
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_final,
    output logic             o_busy,
    output t_dp_cmd          o_cmd,
    output logic [CNT_W-1:0] o_count,
    output t_emit_stat       o_stat
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             w_accept;
    logic             w_room;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign w_room   = r_count < CNT_MAX;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        o_cmd.insert = 1'b1;
                        n_count      = r_count + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // count doubles as the number of items left to unload
                o_cmd.shift_out = 1'b1;
                n_count         = r_count - CNT_ONE;
                if (r_count == CNT_ONE) begin
                    n_state = ST_IDLE;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_busy          = (r_state == ST_EMIT);
    assign o_count         = r_count;
    assign o_stat.valid    = (r_state == ST_EMIT);
    assign o_stat.last     = (r_state == ST_EMIT) && (r_count == CNT_ONE);
    assign o_stat.dropped  = r_ovf;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("record count above capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count != '0))
        else $error("unloading with no records");

    a_final_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_final) |=> (r_state == ST_EMIT))
        else $error("final item did not start unload");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.last |=> (r_state == ST_IDLE && r_count == '0 && !r_ovf))
        else $error("state not cleared after last item");

endmodule
